/* rtl/intel_hex_record_parser_macros.svh */
// Assertion macros shared by the parser RTL.
`ifndef INTEL_HEX_RECORD_PARSER_MACROS_SVH
`define INTEL_HEX_RECORD_PARSER_MACROS_SVH

// Same-cycle implication, inactive while reset is asserted.
`define IHEX_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, inactive while reset is asserted.
`define IHEX_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/ihex_pkg.sv */
package ihex_pkg;

  localparam int unsigned CFG_W      = 17;
  localparam int unsigned BASE_W     = 32;
  localparam int unsigned FULL_ADDR_W = 33;

  localparam logic [CFG_W-1:0] IMAGE_SIZE_RESET = 17'd32768;

  localparam logic [7:0] CHAR_COLON = 8'h3A;
  localparam logic [7:0] CHAR_LF    = 8'h0A;
  localparam logic [7:0] CHAR_CR    = 8'h0D;

  localparam int unsigned MIN_LINE_CHARS = 11;
  // Line position from which the length byte is known.
  localparam int unsigned LEN_KNOWN_POS  = 3;

  localparam logic [7:0] REC_DATA = 8'h00;
  localparam logic [7:0] REC_EOF  = 8'h01;
  localparam logic [7:0] REC_ESA  = 8'h02;
  localparam logic [7:0] REC_ELA  = 8'h04;

  // Byte indices within a record line.
  localparam int unsigned BYTE_LEN      = 0;
  localparam int unsigned BYTE_OFS_HI   = 1;
  localparam int unsigned BYTE_OFS_LO   = 2;
  localparam int unsigned BYTE_TYPE     = 3;
  localparam int unsigned BYTE_DATA0    = 4;
  localparam int unsigned BYTE_DATA1    = 5;

  localparam logic [7:0] EXT_REC_LEN = 8'd2;

  typedef struct packed {
    logic       kind;
    logic [7:0] char_code;
  } in_item_t;

  typedef struct packed {
    logic             write_valid;
    logic [15:0]      write_address;
    logic [7:0]       write_data;
    logic             done_res;
    logic             success;
    logic [CFG_W-1:0] used_size;
    logic             failed;
  } out_item_t;

  // Returns {is_hex, nibble value}.
  function automatic logic [4:0] hex_digit(input logic [7:0] c);
    logic [4:0] res;
    res = 5'b0_0000;
    if (c >= 8'h30 && c <= 8'h39) begin
      res = {1'b1, 4'(c - 8'h30)};
    end else if (c >= 8'h41 && c <= 8'h46) begin
      res = {1'b1, 4'(c - 8'h37)};
    end else if (c >= 8'h61 && c <= 8'h66) begin
      res = {1'b1, 4'(c - 8'h57)};
    end
    return res;
  endfunction

endpackage

/* rtl/ihex_core.sv */
`include "intel_hex_record_parser_macros.svh"

module ihex_core #(
  parameter int ADDRESS_BITS   = 16,
  parameter int MAX_LINE_CHARS = 599
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          item_take,
  input  ihex_pkg::in_item_t            item,
  input  logic                          cfg_take,
  input  logic [ihex_pkg::CFG_W-1:0]    cfg_data,
  output ihex_pkg::out_item_t           result
);

  localparam int LPW = $clog2(MAX_LINE_CHARS + 2);
  localparam int KW  = LPW - 1;
  localparam logic [ihex_pkg::CFG_W-1:0] CAP_LIM =
    (ADDRESS_BITS <= 16) ? (17'd1 << ADDRESS_BITS) : 17'h1FFFF;
  localparam logic [ihex_pkg::CFG_W-1:0] CAP_RESET =
    (ihex_pkg::IMAGE_SIZE_RESET > CAP_LIM) ? CAP_LIM : ihex_pkg::IMAGE_SIZE_RESET;

  logic [LPW-1:0]                       lp_r, lp_nxt;
  logic                                 ignore_r, ignore_nxt;
  logic [3:0]                           hi_nib_r, hi_nib_nxt;
  logic [7:0]                           len_r, len_nxt;
  logic [15:0]                          offset_r, offset_nxt;
  logic [7:0]                           type_r, type_nxt;
  logic [15:0]                          ext_r, ext_nxt;
  logic [7:0]                           sum_r, sum_nxt;
  logic [ihex_pkg::BASE_W-1:0]          base_r, base_nxt;
  logic [ihex_pkg::FULL_ADDR_W-1:0]     addr_r, addr_nxt;
  logic [ihex_pkg::CFG_W-1:0]           hu_r, hu_nxt;
  logic                                 eof_r, eof_nxt;
  logic                                 fault_r, fault_nxt;
  logic [ihex_pkg::CFG_W-1:0]           cap_r, cap_nxt;

  logic [4:0]                           dig;
  logic [7:0]                           byte_val;
  logic [LPW-1:0]                       want;
  logic [KW-1:0]                        k;
  logic [KW-1:0]                        k_limit;
  logic [ihex_pkg::CFG_W-1:0]           addr_inc;
  logic                                 fin_fault;
  logic                                 fin_eof;
  logic [ihex_pkg::BASE_W-1:0]          fin_base;

  assign dig      = ihex_pkg::hex_digit(item.char_code);
  assign byte_val = {hi_nib_r, dig[3:0]};
  assign want     = LPW'(ihex_pkg::MIN_LINE_CHARS) + LPW'({len_r, 1'b0});
  assign k        = lp_r[LPW-1:1] - KW'(1);
  assign k_limit  = KW'(ihex_pkg::BYTE_DATA0) + KW'(len_r);
  assign addr_inc = addr_r[ihex_pkg::CFG_W-1:0] + 17'd1;
  assign cap_nxt  = cfg_take ? ((cfg_data > CAP_LIM) ? CAP_LIM : cfg_data) : cap_r;

  // Checks a completed line and applies its record.
  always_comb begin
    fin_fault = fault_r;
    fin_eof   = eof_r;
    fin_base  = base_r;
    if (lp_r != '0 && !fault_r) begin
      if (lp_r < LPW'(ihex_pkg::MIN_LINE_CHARS) || lp_r != want || sum_r != 8'h00) begin
        fin_fault = 1'b1;
      end else begin
        unique case (type_r)
          ihex_pkg::REC_EOF: begin
            if (len_r != 8'h00) fin_fault = 1'b1;
            else fin_eof = 1'b1;
          end
          ihex_pkg::REC_ESA: begin
            if (len_r != ihex_pkg::EXT_REC_LEN) fin_fault = 1'b1;
            else fin_base = {12'h000, ext_r, 4'h0};
          end
          ihex_pkg::REC_ELA: begin
            if (len_r != ihex_pkg::EXT_REC_LEN) fin_fault = 1'b1;
            else fin_base = {ext_r, 16'h0000};
          end
          default: ;
        endcase
      end
    end
  end

  always_comb begin
    lp_nxt     = lp_r;
    ignore_nxt = ignore_r;
    hi_nib_nxt = hi_nib_r;
    len_nxt    = len_r;
    offset_nxt = offset_r;
    type_nxt   = type_r;
    ext_nxt    = ext_r;
    sum_nxt    = sum_r;
    base_nxt   = base_r;
    addr_nxt   = addr_r;
    hu_nxt     = hu_r;
    eof_nxt    = eof_r;
    fault_nxt  = fault_r;
    result     = '0;

    if (item_take) begin
      if (item.kind) begin
        result.done_res  = 1'b1;
        result.used_size = hu_r;
        result.success   = !fin_fault && fin_eof && (hu_r != '0);
        result.failed    = fin_fault;
        lp_nxt     = '0;
        ignore_nxt = 1'b0;
        hi_nib_nxt = '0;
        len_nxt    = '0;
        offset_nxt = '0;
        type_nxt   = '0;
        ext_nxt    = '0;
        sum_nxt    = '0;
        base_nxt   = '0;
        hu_nxt     = '0;
        eof_nxt    = 1'b0;
        fault_nxt  = 1'b0;
      end else begin
        if (item.char_code == ihex_pkg::CHAR_LF) begin
          fault_nxt  = fin_fault;
          eof_nxt    = fin_eof;
          base_nxt   = fin_base;
          lp_nxt     = '0;
          ignore_nxt = 1'b0;
          hi_nib_nxt = '0;
          len_nxt    = '0;
          offset_nxt = '0;
          type_nxt   = '0;
          ext_nxt    = '0;
          sum_nxt    = '0;
        end else if (item.char_code == ihex_pkg::CHAR_CR) begin
          ignore_nxt = 1'b1;
        end else if (!ignore_r && !fault_r) begin
          lp_nxt = lp_r + LPW'(1);
          if (lp_r >= LPW'(MAX_LINE_CHARS)) begin
            fault_nxt = 1'b1;
          end else if (lp_r == '0) begin
            if (item.char_code != ihex_pkg::CHAR_COLON) fault_nxt = 1'b1;
          end else if (!dig[4] ||
                       (lp_r >= LPW'(ihex_pkg::LEN_KNOWN_POS) && lp_r >= want)) begin
            fault_nxt = 1'b1;
          end else if (lp_r[0]) begin
            hi_nib_nxt = dig[3:0];
          end else begin
            sum_nxt = sum_r + byte_val;
            priority if (k == KW'(ihex_pkg::BYTE_LEN)) begin
              len_nxt = byte_val;
            end else if (k == KW'(ihex_pkg::BYTE_OFS_HI)) begin
              offset_nxt = {byte_val, 8'h00};
            end else if (k == KW'(ihex_pkg::BYTE_OFS_LO)) begin
              offset_nxt = {offset_r[15:8], byte_val};
            end else if (k == KW'(ihex_pkg::BYTE_TYPE)) begin
              type_nxt = byte_val;
              // The start address of the data is fixed once the offset is complete.
              addr_nxt = {1'b0, base_r} + ihex_pkg::FULL_ADDR_W'(offset_r);
            end else begin
              if (k == KW'(ihex_pkg::BYTE_DATA0)) ext_nxt = {byte_val, 8'h00};
              else if (k == KW'(ihex_pkg::BYTE_DATA1)) ext_nxt = {ext_r[15:8], byte_val};
              addr_nxt = addr_r + ihex_pkg::FULL_ADDR_W'(1);
              if (type_r == ihex_pkg::REC_DATA && k < k_limit) begin
                if (addr_r >= ihex_pkg::FULL_ADDR_W'(cap_r)) begin
                  fault_nxt = 1'b1;
                end else begin
                  result.write_valid   = 1'b1;
                  result.write_address = addr_r[15:0];
                  result.write_data    = byte_val;
                  if (addr_inc > hu_r) hu_nxt = addr_inc;
                end
              end
            end
          end
        end
        result.failed = fault_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lp_r     <= '0;
      ignore_r <= 1'b0;
      hi_nib_r <= '0;
      len_r    <= '0;
      offset_r <= '0;
      type_r   <= '0;
      ext_r    <= '0;
      sum_r    <= '0;
      base_r   <= '0;
      hu_r     <= '0;
      eof_r    <= 1'b0;
      fault_r  <= 1'b0;
      cap_r    <= CAP_RESET;
    end else begin
      lp_r     <= lp_nxt;
      ignore_r <= ignore_nxt;
      hi_nib_r <= hi_nib_nxt;
      len_r    <= len_nxt;
      offset_r <= offset_nxt;
      type_r   <= type_nxt;
      ext_r    <= ext_nxt;
      sum_r    <= sum_nxt;
      base_r   <= base_nxt;
      hu_r     <= hu_nxt;
      eof_r    <= eof_nxt;
      fault_r  <= fault_nxt;
      cap_r    <= cap_nxt;
    end
  end

  always_ff @(posedge clk) begin
    addr_r <= addr_nxt;
  end

  `IHEX_ASSERT_NOW(a_no_write_after_fault, clk, rst_n, item_take && result.write_valid, !fault_r, "write issued after a fault")
  `IHEX_ASSERT_NOW(a_write_in_range, clk, rst_n, item_take && result.write_valid, ihex_pkg::CFG_W'(result.write_address) < cap_r, "write at or above capacity")
  `IHEX_ASSERT_NEXT(a_end_clears, clk, rst_n, item_take && item.kind, lp_r == '0 && !fault_r && hu_r == '0 && !eof_r, "state not cleared after end of input")

endmodule

/* rtl/ihex_skid.sv */
`include "intel_hex_record_parser_macros.svh"

module ihex_skid (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  ihex_pkg::out_item_t  in_item,
  output logic                 out_valid,
  input  logic                 out_stall,
  output ihex_pkg::out_item_t  out_item
);

  logic                 out_v_r, out_v_nxt;
  logic                 skid_v_r, skid_v_nxt;
  ihex_pkg::out_item_t  out_d_r, out_d_nxt;
  ihex_pkg::out_item_t  skid_d_r, skid_d_nxt;
  logic                 take_in;
  logic                 out_free;

  assign in_stall  = skid_v_r;
  assign take_in   = in_valid && !skid_v_r;
  assign out_free  = !out_v_r || !out_stall;
  assign out_valid = out_v_r;
  assign out_item  = out_d_r;

  always_comb begin
    out_v_nxt  = out_v_r;
    skid_v_nxt = skid_v_r;
    out_d_nxt  = out_d_r;
    skid_d_nxt = skid_d_r;
    if (out_free) begin
      if (skid_v_r) begin
        out_v_nxt  = 1'b1;
        out_d_nxt  = skid_d_r;
        skid_v_nxt = 1'b0;
      end else begin
        out_v_nxt = take_in;
        out_d_nxt = in_item;
      end
    end else if (take_in) begin
      // Output is held, so the new transfer parks in the skid stage.
      skid_v_nxt = 1'b1;
      skid_d_nxt = in_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else begin
      out_v_r  <= out_v_nxt;
      skid_v_r <= skid_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_d_r  <= out_d_nxt;
    skid_d_r <= skid_d_nxt;
  end

  `IHEX_ASSERT_NOW(a_skid_behind_out, clk, rst_n, skid_v_r, out_v_r, "skid stage full while output empty")
  `IHEX_ASSERT_NEXT(a_skid_fill_cause, clk, rst_n, !skid_v_r && !(out_v_r && out_stall), !skid_v_r, "skid stage filled without a held output")
  `IHEX_ASSERT_NEXT(a_skid_drains, clk, rst_n, skid_v_r && !out_stall, !skid_v_r, "skid stage did not drain")

endmodule

/* rtl/intel_hex_record_parser.sv */
// Throughput: one item per cycle while in_stall is low; results are registered
// in the output buffer, and the whole record decode sits in one register stage.
// A two-entry output buffer lets the input keep flowing while one result is held.
// Reset (rst_n, synchronous, active low) clears the parser state and flags
// and returns image_size to 32768, limited to the address range.
module intel_hex_record_parser #(
  parameter int ADDRESS_BITS   = 16,
  parameter int MAX_LINE_CHARS = 599
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  ihex_pkg::in_item_t          in_data,
  output logic                        out_valid,
  input  logic                        out_stall,
  output ihex_pkg::out_item_t         out_data,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [ihex_pkg::CFG_W-1:0]  cfg_data
);

  logic                 item_take;
  ihex_pkg::out_item_t  result;

  assign cfg_ready = 1'b1;
  assign item_take = in_valid && !in_stall;

  ihex_core #(
    .ADDRESS_BITS   (ADDRESS_BITS),
    .MAX_LINE_CHARS (MAX_LINE_CHARS)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .item_take (item_take),
    .item      (in_data),
    .cfg_take  (cfg_valid),
    .cfg_data  (cfg_data),
    .result    (result)
  );

  ihex_skid u_skid (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (item_take),
    .in_stall  (in_stall),
    .in_item   (result),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_data)
  );

endmodule

/* sim/tb.sv */
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ADDRESS_BITS   = 16;
  localparam int MAX_LINE_CHARS = 599;
  localparam longint unsigned ADDR_SPAN = 64'd1 << ADDRESS_BITS;
  localparam int unsigned POS_SATURATE   = 1023;
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int RANDOM_ITEMS   = 300;
  localparam logic [ihex_pkg::CFG_W-1:0] SIZE_FULL = 17'd65536;

  typedef enum {
    FLAW_NONE, FLAW_NO_COLON, FLAW_BAD_DIGIT, FLAW_BAD_SUM, FLAW_EXTRA_BYTE, FLAW_NO_CHECKSUM
  } flaw_t;
  typedef enum {EOL_LF, EOL_CRLF, EOL_CR_JUNK, EOL_NONE} eol_t;

  logic                           clk = 1'b0;
  logic                           rst_n = 1'b0;
  logic                           in_valid = 1'b0;
  logic                           in_stall;
  ihex_pkg::in_item_t             in_data = '0;
  logic                           out_valid;
  logic                           out_stall = 1'b0;
  ihex_pkg::out_item_t            out_data;
  logic                           cfg_valid = 1'b0;
  logic                           cfg_ready;
  logic [ihex_pkg::CFG_W-1:0]     cfg_data = '0;

  // Model of the parser state, advanced on every accepted item.
  logic [ihex_pkg::CFG_W-1:0] size_reg;
  int unsigned      line_pos;
  bit               skip_to_lf;
  logic [3:0]       hi_nib;
  logic [7:0]       rec_len;
  logic [7:0]       rec_type;
  logic [7:0]       run_sum;
  logic [15:0]      rec_ofs;
  logic [15:0]      ext_val;
  logic [15:0]      lin_base;
  logic [15:0]      seg_base;
  logic [ihex_pkg::CFG_W-1:0] top_used;
  bit               eof_seen;
  bit               img_fault;

  ihex_pkg::out_item_t predicted_results[$];

  bit feed_calm = 1'b0;
  bit sink_calm = 1'b0;
  int mismatches = 0;
  int items_sent = 0;
  int images_seen = 0;
  int images_clean = 0;
  int writes_seen = 0;
  int size_settings = 0;
  int quiet_cycles = 0;

  always #1 clk = ~clk;

  intel_hex_record_parser #(
    .ADDRESS_BITS  (ADDRESS_BITS),
    .MAX_LINE_CHARS(MAX_LINE_CHARS)
  ) i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data)
  );

  function automatic int hex_value(input logic [7:0] c);
    if (c >= 8'h30 && c <= 8'h39) return int'(c) - 'h30;
    if (c >= 8'h41 && c <= 8'h46) return int'(c) - 'h41 + 10;
    if (c >= 8'h61 && c <= 8'h66) return int'(c) - 'h61 + 10;
    return -1;
  endfunction

  function automatic void clear_record();
    line_pos   = 0;
    skip_to_lf = 1'b0;
    hi_nib     = '0;
    rec_len    = '0;
    rec_ofs    = '0;
    rec_type   = '0;
    ext_val    = '0;
    run_sum    = '0;
  endfunction

  function automatic void clear_image();
    clear_record();
    lin_base  = '0;
    seg_base  = '0;
    top_used  = '0;
    eof_seen  = 1'b0;
    img_fault = 1'b0;
  endfunction

  // Line-level checks, applied at a line feed or at the end mark.
  function automatic void close_record();
    int unsigned full_len;
    full_len = ihex_pkg::MIN_LINE_CHARS + 2 * rec_len;
    if (line_pos != 0 && !img_fault) begin
      if (line_pos < ihex_pkg::MIN_LINE_CHARS || line_pos != full_len ||
          run_sum != 8'h00) begin
        img_fault = 1'b1;
      end else if (rec_type == ihex_pkg::REC_EOF) begin
        if (rec_len != 8'h00) img_fault = 1'b1;
        else eof_seen = 1'b1;
      end else if (rec_type == ihex_pkg::REC_ESA) begin
        if (rec_len != ihex_pkg::EXT_REC_LEN) begin
          img_fault = 1'b1;
        end else begin
          seg_base = ext_val;
          lin_base = '0;
        end
      end else if (rec_type == ihex_pkg::REC_ELA) begin
        if (rec_len != ihex_pkg::EXT_REC_LEN) begin
          img_fault = 1'b1;
        end else begin
          lin_base = ext_val;
          seg_base = '0;
        end
      end
    end
    clear_record();
  endfunction

  function automatic ihex_pkg::out_item_t predict_item(input ihex_pkg::in_item_t it);
    ihex_pkg::out_item_t r;
    int              digit;
    int unsigned     p;
    int unsigned     k;
    logic [7:0]      b;
    longint unsigned addr;
    longint unsigned cap;
    r = '0;
    if (it.kind) begin
      close_record();
      r.done_res  = 1'b1;
      r.used_size = top_used;
      r.success   = !img_fault && eof_seen && top_used != 0;
      r.failed    = img_fault;
      clear_image();
    end else begin
      if (it.char_code == ihex_pkg::CHAR_LF) begin
        close_record();
      end else if (it.char_code == ihex_pkg::CHAR_CR) begin
        skip_to_lf = 1'b1;
      end else if (!skip_to_lf && !img_fault) begin
        p = line_pos;
        digit = hex_value(it.char_code);
        if (p >= MAX_LINE_CHARS) begin
          img_fault = 1'b1;
        end else if (p == 0) begin
          if (it.char_code != ihex_pkg::CHAR_COLON) img_fault = 1'b1;
        end else if (digit < 0 ||
                     (p >= ihex_pkg::LEN_KNOWN_POS &&
                      p >= ihex_pkg::MIN_LINE_CHARS + 2 * rec_len)) begin
          img_fault = 1'b1;
        end else if (p % 2 == 1) begin
          hi_nib = digit[3:0];
        end else begin
          b = {hi_nib, digit[3:0]};
          k = (p - 2) / 2;
          run_sum = run_sum + b;
          case (k)
            ihex_pkg::BYTE_LEN:    rec_len = b;
            ihex_pkg::BYTE_OFS_HI: rec_ofs = {b, 8'h00};
            ihex_pkg::BYTE_OFS_LO: rec_ofs = rec_ofs | 16'(b);
            ihex_pkg::BYTE_TYPE:   rec_type = b;
            default: begin
              if (k == ihex_pkg::BYTE_DATA0) ext_val = {b, 8'h00};
              else if (k == ihex_pkg::BYTE_DATA1) ext_val = ext_val | 16'(b);
              if (rec_type == ihex_pkg::REC_DATA && k < ihex_pkg::BYTE_DATA0 + rec_len) begin
                cap = (size_reg > ADDR_SPAN) ? ADDR_SPAN : 64'(size_reg);
                addr = (64'(lin_base) << 16) + (64'(seg_base) << 4) + 64'(rec_ofs)
                     + 64'(k - ihex_pkg::BYTE_DATA0);
                if (addr >= cap) begin
                  img_fault = 1'b1;
                end else begin
                  r.write_valid   = 1'b1;
                  r.write_address = addr[15:0];
                  r.write_data    = b;
                  if (addr + 1 > top_used) top_used = ihex_pkg::CFG_W'(addr + 1);
                end
              end
            end
          endcase
        end
        if (line_pos < POS_SATURATE) line_pos++;
      end
      r.failed = img_fault;
    end
    return r;
  endfunction

  task automatic send_item(input ihex_pkg::in_item_t it);
    int unsigned gap;
    gap = feed_calm ? 0 : $urandom_range(0, 11);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (in_stall);
    predicted_results.push_back(predict_item(it));
    items_sent++;
  endtask

  task automatic send_char(input logic [7:0] c);
    ihex_pkg::in_item_t it;
    it.kind      = 1'b0;
    it.char_code = c;
    send_item(it);
  endtask

  // The character field carries random bits on the end mark as well.
  task automatic send_end();
    ihex_pkg::in_item_t it;
    it.kind      = 1'b1;
    it.char_code = 8'($urandom);
    send_item(it);
  endtask

  task automatic send_text(input string s);
    int i;
    for (i = 0; i < s.len(); i++) send_char(s[i]);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (predicted_results.size() != 0) @(posedge clk);
  endtask

  task automatic set_image_size(input logic [ihex_pkg::CFG_W-1:0] v);
    drain_results();
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    size_reg = v;
    size_settings++;
  endtask

  function automatic logic [7:0] nibble_char(input logic [3:0] n);
    if (n < 4'd10) return 8'h30 + 8'(n);
    return (($urandom_range(0, 1) != 0) ? 8'h61 : 8'h41) + 8'(n) - 8'd10;
  endfunction

  function automatic logic [7:0] not_lf_char();
    logic [7:0] c;
    do c = 8'($urandom); while (c == ihex_pkg::CHAR_LF);
    return c;
  endfunction

  // Anything that is neither a hex digit, a colon nor a line terminator.
  function automatic logic [7:0] stray_char();
    logic [7:0] c;
    do c = 8'($urandom);
    while (hex_value(c) >= 0 || c == ihex_pkg::CHAR_COLON || c == ihex_pkg::CHAR_LF ||
           c == ihex_pkg::CHAR_CR);
    return c;
  endfunction

  function automatic flaw_t pick_flaw();
    if ($urandom_range(0, 99) < 92) return FLAW_NONE;
    return flaw_t'($urandom_range(FLAW_NO_COLON, FLAW_NO_CHECKSUM));
  endfunction

  function automatic eol_t pick_eol();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 50) return EOL_LF;
    if (r < 85) return EOL_CRLF;
    return EOL_CR_JUNK;
  endfunction

  task automatic end_line(input eol_t eol);
    int unsigned junk;
    case (eol)
      EOL_LF: send_char(ihex_pkg::CHAR_LF);
      EOL_CRLF: begin
        send_char(ihex_pkg::CHAR_CR);
        send_char(ihex_pkg::CHAR_LF);
      end
      EOL_CR_JUNK: begin
        send_char(ihex_pkg::CHAR_CR);
        junk = $urandom_range(1, 6);
        repeat (junk) send_char(not_lf_char());
        send_char(ihex_pkg::CHAR_LF);
      end
      default: ;
    endcase
  endtask

  // The first two payload bytes come from lead, the rest are random.
  task automatic send_record(input logic [7:0] rtype, input logic [15:0] ofs,
                             input int unsigned len, input logic [15:0] lead,
                             input flaw_t flaw, input eol_t eol);
    logic [7:0]  octs [0:263];
    logic [7:0]  txt  [0:599];
    int unsigned n_oct;
    int unsigned n_txt;
    int unsigned i;
    logic [7:0]  sum;
    octs[0] = len[7:0];
    octs[1] = ofs[15:8];
    octs[2] = ofs[7:0];
    octs[3] = rtype;
    n_oct = 4;
    for (i = 0; i < len; i++) begin
      octs[n_oct] = (i == 0) ? lead[15:8] : (i == 1) ? lead[7:0] : 8'($urandom);
      n_oct++;
    end
    sum = '0;
    for (i = 0; i < n_oct; i++) sum = sum + octs[i];
    octs[n_oct] = 8'h00 - sum;
    n_oct++;
    case (flaw)
      FLAW_BAD_SUM: octs[n_oct-1] = octs[n_oct-1] ^ (8'h01 << $urandom_range(0, 7));
      FLAW_EXTRA_BYTE: begin
        octs[n_oct] = 8'($urandom);
        n_oct++;
      end
      FLAW_NO_CHECKSUM: n_oct--;
      default: ;
    endcase
    txt[0] = (flaw == FLAW_NO_COLON) ? stray_char() : ihex_pkg::CHAR_COLON;
    n_txt = 1;
    for (i = 0; i < n_oct; i++) begin
      txt[n_txt]   = nibble_char(octs[i][7:4]);
      txt[n_txt+1] = nibble_char(octs[i][3:0]);
      n_txt += 2;
    end
    if (flaw == FLAW_BAD_DIGIT) txt[$urandom_range(1, n_txt - 1)] = stray_char();
    for (i = 0; i < n_txt; i++) send_char(txt[i]);
    end_line(eol);
  endtask

  task automatic test_plain_image();
    feed_calm = 1'b1;
    sink_calm = 1'b1;
    set_image_size(ihex_pkg::IMAGE_SIZE_RESET);
    send_text("\n");
    send_record(ihex_pkg::REC_DATA, 16'h0000, 1, 16'hFF00, FLAW_NONE, EOL_LF);
    send_record(ihex_pkg::REC_DATA, 16'h7FFC, 4, 16'h00FF, FLAW_NONE, EOL_CRLF);
    send_record(8'h03, 16'h1234, 4, 16'hA55A, FLAW_NONE, EOL_CR_JUNK);
    send_text("\n");
    send_record(ihex_pkg::REC_EOF, 16'h0000, 0, 16'h0000, FLAW_NONE, EOL_LF);
    send_end();
    feed_calm = 1'b0;
    sink_calm = 1'b0;
  endtask

  task automatic test_extended_addressing();
    set_image_size(SIZE_FULL);
    // The segment base puts the last sixteen bytes at the very top of the space.
    send_record(ihex_pkg::REC_ESA, 16'h0000, 2, 16'h0FFF, FLAW_NONE, EOL_LF);
    send_record(ihex_pkg::REC_DATA, 16'h0000, 16, 16'h5AA5, FLAW_NONE, EOL_LF);
    send_record(ihex_pkg::REC_ELA, 16'h0000, 2, 16'h0000, FLAW_NONE, EOL_CRLF);
    send_record(ihex_pkg::REC_DATA, 16'h0100, 255, 16'hFF00, FLAW_NONE, EOL_LF);
    send_record(8'h05, 16'hFFFF, 2, 16'h1234, FLAW_NONE, EOL_LF);
    send_record(8'hFF, 16'h0000, 0, 16'h0000, FLAW_NONE, EOL_LF);
    send_record(ihex_pkg::REC_EOF, 16'h0000, 0, 16'h0000, FLAW_NONE, EOL_LF);
    send_end();
    // A linear base of one lies wholly outside a 64 KiB image.
    send_record(ihex_pkg::REC_ELA, 16'h0000, 2, 16'h0001, FLAW_NONE, EOL_LF);
    send_record(ihex_pkg::REC_DATA, 16'h0000, 1, 16'h0000, FLAW_NONE, EOL_LF);
    send_record(ihex_pkg::REC_EOF, 16'h0000, 0, 16'h0000, FLAW_NONE, EOL_LF);
    send_end();
  endtask

  task automatic test_line_faults();
    int f;
    for (f = FLAW_NO_COLON; f <= FLAW_NO_CHECKSUM; f++) begin
      send_record(ihex_pkg::REC_DATA, 16'h0010, 2, 16'hC33C, FLAW_NONE, EOL_LF);
      send_record(ihex_pkg::REC_DATA, 16'h0020, 3, 16'h0102, flaw_t'(f), EOL_LF);
      send_record(ihex_pkg::REC_EOF, 16'h0000, 0, 16'h0000, FLAW_NONE, EOL_LF);
      send_end();
    end
    send_text(":00\n");
    send_end();
    send_record(ihex_pkg::REC_EOF, 16'h0000, 1, 16'h0000, FLAW_NONE, EOL_LF);
    send_end();
    send_record(ihex_pkg::REC_ESA, 16'h0000, 1, 16'h1000, FLAW_NONE, EOL_LF);
    send_end();
    send_record(ihex_pkg::REC_ELA, 16'h0000, 3, 16'h0000, FLAW_NONE, EOL_LF);
    send_end();
    // Missing end record, then an end record with nothing written.
    send_record(ihex_pkg::REC_DATA, 16'h0000, 1, 16'h7700, FLAW_NONE, EOL_LF);
    send_end();
    send_record(ihex_pkg::REC_EOF, 16'h0000, 0, 16'h0000, FLAW_NONE, EOL_LF);
    send_end();
    // The final line has no terminator and is checked at the end mark.
    send_record(ihex_pkg::REC_DATA, 16'h0040, 2, 16'h8001, FLAW_NONE, EOL_LF);
    send_record(ihex_pkg::REC_EOF, 16'h0000, 0, 16'h0000, FLAW_NONE, EOL_NONE);
    send_end();
  endtask

  task automatic test_capacity_limits();
    set_image_size(17'd1);
    send_record(ihex_pkg::REC_DATA, 16'h0000, 1, 16'hAB00, FLAW_NONE, EOL_LF);
    send_record(ihex_pkg::REC_EOF, 16'h0000, 0, 16'h0000, FLAW_NONE, EOL_LF);
    send_end();
    send_record(ihex_pkg::REC_DATA, 16'h0000, 2, 16'hCDEF, FLAW_NONE, EOL_LF);
    send_end();
    send_record(ihex_pkg::REC_DATA, 16'h0001, 1, 16'h1100, FLAW_NONE, EOL_LF);
    send_end();
    set_image_size(17'd65535);
    send_record(ihex_pkg::REC_DATA, 16'hFFFE, 2, 16'h2233, FLAW_NONE, EOL_LF);
    send_record(ihex_pkg::REC_EOF, 16'h0000, 0, 16'h0000, FLAW_NONE, EOL_LF);
    send_end();
  endtask

  // One image of mostly well-formed records whose addresses are aimed inside
  // the current capacity, with the odd broken or foreign line mixed in.
  task automatic random_image();
    int unsigned cap;
    int unsigned base_addr;
    int unsigned avail;
    int unsigned len;
    int unsigned ofs;
    int unsigned n_rec;
    int unsigned pick;
    int unsigned n;
    logic [15:0] v;
    logic [7:0]  t;
    cap = (size_reg > SIZE_FULL) ? SIZE_FULL : size_reg;
    base_addr = 0;
    feed_calm = ($urandom_range(0, 4) == 0);
    sink_calm = ($urandom_range(0, 4) == 0);
    n_rec = $urandom_range(1, 10);
    repeat (n_rec) begin
      pick = $urandom_range(0, 99);
      if (pick < 8) begin
        v = 16'($urandom_range(0, (cap - 1) >> 4));
        base_addr = int'(v) << 4;
        send_record(ihex_pkg::REC_ESA, 16'($urandom), 2, v, pick_flaw(), pick_eol());
      end else if (pick < 12) begin
        v = ($urandom_range(0, 3) == 0) ? 16'h0001 : 16'h0000;
        base_addr = int'(v) << 16;
        send_record(ihex_pkg::REC_ELA, 16'($urandom), 2, v, pick_flaw(), pick_eol());
      end else if (pick < 16) begin
        do t = 8'($urandom);
        while (t == ihex_pkg::REC_DATA || t == ihex_pkg::REC_EOF ||
               t == ihex_pkg::REC_ESA || t == ihex_pkg::REC_ELA);
        send_record(t, 16'($urandom), $urandom_range(0, 4), 16'($urandom), pick_flaw(),
                    pick_eol());
      end else if (pick < 20) begin
        n = $urandom_range(1, 20);
        repeat (n) send_char(not_lf_char());
        send_char(ihex_pkg::CHAR_LF);
      end else begin
        avail = (cap > base_addr) ? cap - base_addr : 0;
        len = ($urandom_range(0, 19) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
        if (avail == 0) begin
          ofs = $urandom_range(0, 16'hFFFF);
        end else begin
          if (len > avail) len = avail;
          n = avail - len;
          ofs = $urandom_range(0, (n > 16'hFFFF) ? 16'hFFFF : n);
        end
        send_record(ihex_pkg::REC_DATA, 16'(ofs), len, 16'($urandom), pick_flaw(),
                    pick_eol());
      end
    end
    if ($urandom_range(0, 9) != 0) begin
      send_record(ihex_pkg::REC_EOF, 16'h0000, 0, 16'h0000, pick_flaw(),
                  ($urandom_range(0, 7) == 0) ? EOL_NONE : pick_eol());
    end
    send_end();
  endtask

  task automatic test_random_images();
    int start;
    start = items_sent;
    while (items_sent - start < RANDOM_ITEMS) begin
      if ($urandom_range(0, 3) == 0) begin
        case ($urandom_range(0, 7))
          0: set_image_size(17'd1);
          1: set_image_size(17'd16);
          2: set_image_size(17'd255);
          3: set_image_size(17'd4096);
          4: set_image_size(ihex_pkg::IMAGE_SIZE_RESET);
          5: set_image_size(17'd65535);
          6: set_image_size(SIZE_FULL);
          default: set_image_size(ihex_pkg::CFG_W'($urandom_range(1, 65536)));
        endcase
      end
      random_image();
    end
  endtask

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      mismatches++;
    end
  endfunction

  // Receiver side: a fresh hold-off is drawn before each result transfer.
  initial begin : result_sink
    int unsigned hold;
    forever begin
      hold = sink_calm ? 0 : $urandom_range(0, 11);
      if (hold != 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
        out_stall <= 1'b0;
      end
      do @(posedge clk); while (!(out_valid && !out_stall));
    end
  end

  always @(posedge clk) begin : result_check
    ihex_pkg::out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (predicted_results.size() == 0) begin
        $error("Result with no item outstanding: 0x%0h", out_data);
        mismatches++;
      end else begin
        want = predicted_results.pop_front();
        check_field("write_valid", want.write_valid, out_data.write_valid);
        check_field("write_address", want.write_address, out_data.write_address);
        check_field("write_data", want.write_data, out_data.write_data);
        check_field("done_res", want.done_res, out_data.done_res);
        check_field("success", want.success, out_data.success);
        check_field("used_size", want.used_size, out_data.used_size);
        check_field("failed", want.failed, out_data.failed);
      end
      if (out_data.write_valid === 1'b1) writes_seen++;
      if (out_data.done_res === 1'b1) begin
        images_seen++;
        if (out_data.success === 1'b1) images_clean++;
      end
    end
  end

  always @(posedge clk) begin : watchdog
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $error("No transfer for %0d cycles, giving up", quiet_cycles);
      $display("FAIL");
      $finish;
    end
  end

  initial begin : run
    size_reg = ihex_pkg::IMAGE_SIZE_RESET;
    clear_image();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_plain_image();
    test_extended_addressing();
    test_line_faults();
    test_capacity_limits();
    test_random_images();
    drain_results();
    repeat (4) @(posedge clk);
    if (predicted_results.size() != 0) begin
      $error("%0d results never arrived", predicted_results.size());
      mismatches++;
    end
    $display("Sent %0d characters and end marks over %0d image-size settings.",
             items_sent, size_settings);
    $display("Saw %0d images (%0d accepted) and %0d byte writes; %0d mismatches.",
             images_seen, images_clean, writes_seen, mismatches);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

/* sim.f */
+incdir+rtl
rtl/ihex_pkg.sv
rtl/ihex_core.sv
rtl/ihex_skid.sv
rtl/intel_hex_record_parser.sv
sim/tb.sv
